/* rtl/slvl_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, stage map and types for the soft-limit velocity limiter.
package slvl_pkg;

  // Divider: quotient bits per stage and number of stages
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = 8;
  localparam int U_W        = DIV_BITS * DIV_STAGES;

  // Pipeline stage map
  localparam int ST_DIFF    = 0;
  localparam int ST_ZONE    = 1;
  localparam int ST_DIV0    = 2;
  localparam int ST_SQ      = ST_DIV0 + DIV_STAGES;
  localparam int ST_CUBE    = ST_SQ + 1;
  localparam int ST_SMOOTH  = ST_CUBE + 1;
  localparam int ST_SCALE   = ST_SMOOTH + 1;
  localparam int ST_PROD    = ST_SCALE + 1;
  localparam int ST_OUT     = ST_PROD + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [16:0] Q16_ONE          = 17'd65536;
  localparam logic [15:0] SCALE_FLOOR      = 16'd6554;
  localparam logic [15:0] SCALE_SPAN       = 16'd58982;
  localparam logic [23:0] ACTIVE_THRESHOLD = 24'd25;
  localparam logic [20:0] SMOOTH_C10       = 21'd655360;
  localparam logic [20:0] SMOOTH_C6        = 21'd6;
  localparam logic [20:0] SMOOTH_C15       = 21'd15;

  localparam logic signed [31:0] LOWER_LIMIT_RST = -32'sd1600000;
  localparam logic signed [31:0] UPPER_LIMIT_RST = 32'sd1600000;
  localparam logic [15:0]        MAX_SPEED_RST   = 16'd8000;
  localparam logic [8:0]         PREC_GAIN_RST   = 9'd64;
  localparam logic [8:0]         USTEP_RST       = 9'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_LIMIT      = 3'd0,
    REG_UPPER_LIMIT      = 3'd1,
    REG_MAX_SPEED        = 3'd2,
    REG_PRECISION_ENABLE = 3'd3,
    REG_PRECISION_GAIN   = 3'd4,
    REG_MICROSTEP_FACTOR = 3'd5
  } slvl_reg_t;

  typedef struct packed {
    logic signed [31:0] lower;
    logic signed [31:0] upper;
  } slvl_limits_t;

  typedef logic [ST_SCALE:0] slvl_scale_load_t;

endpackage

/* rtl/slvl_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command, result and register write.
interface slvl_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] requested_velocity;
  logic signed [31:0] current_position;

  modport source (output valid, output requested_velocity, output current_position,
                  input ready);
  modport sink (input valid, input requested_velocity, input current_position,
                output ready);
endinterface

interface slvl_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] drive_velocity;
  logic               axis_active;

  modport source (output valid, output drive_velocity, output axis_active, input ready);
  modport sink (input valid, input drive_velocity, input axis_active, output ready);
endinterface

interface slvl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [slvl_pkg::CFG_IDX_W-1:0]   index;
  logic [slvl_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/slvl_scale_pipe.sv */
`timescale 1ns / 1ps
// Soft-limit scale pipeline: zone test, fractional divider, smootherstep, Q1.16 scale.
module slvl_scale_pipe (
  input  logic                       clk,
  input  slvl_pkg::slvl_scale_load_t load,
  input  logic signed [31:0]         pos,
  input  slvl_pkg::slvl_limits_t     lim,
  output logic [16:0]                scale
);

  localparam int DS = slvl_pkg::DIV_STAGES;
  localparam int UW = slvl_pkg::U_W;

  function automatic logic signed [37:0] times20(input logic signed [32:0] d);
    logic signed [37:0] e;
    e = 38'(d);
    return (e <<< 4) + (e <<< 2);
  endfunction

  // Distances to both limits
  logic signed [32:0] range0_r, dmin0_r, dmax0_r;

  always_ff @(posedge clk) begin
    if (load[slvl_pkg::ST_DIFF]) begin
      range0_r <= 33'(lim.upper) - 33'(lim.lower);
      dmin0_r  <= 33'(pos) - 33'(lim.lower);
      dmax0_r  <= 33'(lim.upper) - 33'(pos);
    end
  end

  // Pick the zone, lower limit first
  logic signed [37:0] t20min, t20max, d20;
  logic signed [32:0] d_sel;
  logic               in_lo, in_hi, rng_pos;
  logic [31:0]        a1_nxt, a1_r, rng1_r;
  logic               full1_nxt, full1_r;

  always_comb begin
    t20min    = times20(dmin0_r);
    t20max    = times20(dmax0_r);
    in_lo     = t20min < 38'(range0_r);
    in_hi     = t20max < 38'(range0_r);
    rng_pos   = range0_r > 33'sd0;
    d_sel     = in_lo ? dmin0_r : dmax0_r;
    d20       = in_lo ? t20min : t20max;
    a1_nxt    = (d_sel > 33'sd0) ? d20[31:0] : 32'd0;
    full1_nxt = !rng_pos || !(in_lo || in_hi);
  end

  always_ff @(posedge clk) begin
    if (load[slvl_pkg::ST_ZONE]) begin
      a1_r    <= a1_nxt;
      rng1_r  <= range0_r[31:0];
      full1_r <= full1_nxt;
    end
  end

  // Fractional long division u = a * 2^16 / range, a < range
  logic [31:0]   rem_r  [DS];
  logic [UW-1:0] q_r    [DS];
  logic [31:0]   rng_r  [DS];
  logic          full_r [DS];
  logic [31:0]   rem_src  [DS];
  logic [UW-1:0] q_src    [DS];
  logic [31:0]   rng_src  [DS];
  logic          full_src [DS];
  logic [31:0]   rem_nxt  [DS];
  logic [UW-1:0] q_nxt    [DS];

  always_comb begin
    rem_src[0]  = a1_r;
    q_src[0]    = '0;
    rng_src[0]  = rng1_r;
    full_src[0] = full1_r;
    for (int j = 1; j < DS; j++) begin
      rem_src[j]  = rem_r[j-1];
      q_src[j]    = q_r[j-1];
      rng_src[j]  = rng_r[j-1];
      full_src[j] = full_r[j-1];
    end
  end

  always_comb begin
    logic [32:0] t;
    logic        ge;
    for (int j = 0; j < DS; j++) begin
      rem_nxt[j] = rem_src[j];
      q_nxt[j]   = q_src[j];
      for (int b = 0; b < slvl_pkg::DIV_BITS; b++) begin
        t          = {rem_nxt[j], 1'b0};
        ge         = t >= {1'b0, rng_src[j]};
        rem_nxt[j] = ge ? 32'(t - {1'b0, rng_src[j]}) : t[31:0];
        q_nxt[j]   = {q_nxt[j][UW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DS; j++) begin
      if (load[slvl_pkg::ST_DIV0 + j]) begin
        rem_r[j]  <= rem_nxt[j];
        q_r[j]    <= q_nxt[j];
        rng_r[j]  <= rng_src[j];
        full_r[j] <= full_src[j];
      end
    end
  end

  // Smootherstep in Q0.16
  logic [UW-1:0] u_r, u2_r, u3_r;
  logic [19:0]   p_r;
  logic [16:0]   s_r;
  logic          full_sq_r, full_cube_r, full_sm_r;
  logic [31:0]   sq_prod, cube_prod;
  logic [35:0]   sm_prod;
  logic [33:0]   span_prod;

  assign sq_prod   = 32'(q_r[DS-1]) * 32'(q_r[DS-1]);
  assign cube_prod = 32'(u2_r) * 32'(u_r);
  assign sm_prod   = 36'(u3_r) * 36'(p_r);
  assign span_prod = 34'(slvl_pkg::SCALE_SPAN) * 34'(s_r) + 34'd32768;

  always_ff @(posedge clk) begin
    if (load[slvl_pkg::ST_SQ]) begin
      u_r       <= q_r[DS-1];
      u2_r      <= sq_prod[31:16];
      full_sq_r <= full_r[DS-1];
    end
    if (load[slvl_pkg::ST_CUBE]) begin
      u3_r        <= cube_prod[31:16];
      p_r         <= 20'(slvl_pkg::SMOOTH_C10 + 21'(u2_r) * slvl_pkg::SMOOTH_C6
                         - 21'(u_r) * slvl_pkg::SMOOTH_C15);
      full_cube_r <= full_sq_r;
    end
    if (load[slvl_pkg::ST_SMOOTH]) begin
      s_r       <= sm_prod[32:16];
      full_sm_r <= full_cube_r;
    end
    if (load[slvl_pkg::ST_SCALE]) begin
      scale <= full_sm_r ? slvl_pkg::Q16_ONE
                         : 17'(slvl_pkg::SCALE_FLOOR) + 17'(span_prod[33:16]);
    end
  end

endmodule

/* rtl/soft_limit_velocity_limiter_top.sv */
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while out_chan.ready is high; every stage
// holds a valid bit and loads whenever it is empty or the stage after it moves, so
// bubbles are squeezed out.
// Stall: out_chan.ready low holds the output register; upstream keeps filling.
// Reset: synchronous, active low; clears all valid bits and loads register defaults.
module soft_limit_velocity_limiter_top (
  input  logic              clk,
  input  logic              rst_n,
  slvl_in_if.sink           in_chan,
  slvl_out_if.source        out_chan,
  slvl_cfg_if.sink          cfg_chan
);

  localparam int NST = slvl_pkg::NUM_STAGES;

  typedef struct packed {
    logic        neg;
    logic        zero;
    logic [32:0] mag;
  } vel_t;

  // Configuration registers
  logic signed [31:0] lower_r, upper_r;
  logic [15:0]        max_speed_r;
  logic               prec_en_r;
  logic [8:0]         prec_gain_r, ustep_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r     <= slvl_pkg::LOWER_LIMIT_RST;
      upper_r     <= slvl_pkg::UPPER_LIMIT_RST;
      max_speed_r <= slvl_pkg::MAX_SPEED_RST;
      prec_en_r   <= 1'b0;
      prec_gain_r <= slvl_pkg::PREC_GAIN_RST;
      ustep_r     <= slvl_pkg::USTEP_RST;
    end else if (cfg_chan.valid) begin
      case (slvl_pkg::slvl_reg_t'(cfg_chan.index))
        slvl_pkg::REG_LOWER_LIMIT:      lower_r     <= cfg_chan.data;
        slvl_pkg::REG_UPPER_LIMIT:      upper_r     <= cfg_chan.data;
        slvl_pkg::REG_MAX_SPEED:        max_speed_r <= cfg_chan.data[15:0];
        slvl_pkg::REG_PRECISION_ENABLE: prec_en_r   <= cfg_chan.data[0];
        slvl_pkg::REG_PRECISION_GAIN:   prec_gain_r <= cfg_chan.data[8:0];
        slvl_pkg::REG_MICROSTEP_FACTOR: ustep_r     <= cfg_chan.data[8:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and load enables
  logic [NST-1:0] valid_r, load;

  always_comb begin
    load[NST-1] = !valid_r[NST-1] || out_chan.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      load[k] = !valid_r[k] || load[k+1];
    end
  end

  assign in_chan.ready = load[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (load[0]) valid_r[0] <= in_chan.valid;
      for (int k = 1; k < NST; k++) begin
        if (load[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  // Velocity path
  vel_t        vel_r [slvl_pkg::ST_PROD:0];
  vel_t        vel0_nxt, vel1_nxt, vel_prod_nxt;
  logic [23:0] req_abs;
  logic        req_neg;
  logic [41:0] prec_prod;
  logic [50:0] scale_prod;
  logic [16:0] scale;

  always_comb begin
    req_neg       = in_chan.requested_velocity[23];
    req_abs       = req_neg ? (~in_chan.requested_velocity + 24'd1)
                            : in_chan.requested_velocity;
    vel0_nxt.neg  = req_neg;
    // a command into a limit already reached drives zero
    vel0_nxt.zero = req_neg ? (in_chan.current_position <= lower_r)
                            : (in_chan.current_position >= upper_r);
    vel0_nxt.mag  = {1'b0, 32'(req_abs) * 32'(ustep_r)};
  end

  always_comb begin
    prec_prod = 42'(vel_r[0].mag) * 42'(prec_gain_r) + 42'd128;
    vel1_nxt  = vel_r[0];
    if (prec_en_r) vel1_nxt.mag = prec_prod[40:8];
  end

  always_comb begin
    scale_prod       = 51'(vel_r[slvl_pkg::ST_SCALE].mag) * 51'(scale) + 51'd32768;
    vel_prod_nxt     = vel_r[slvl_pkg::ST_SCALE];
    vel_prod_nxt.mag = vel_r[slvl_pkg::ST_SCALE].zero ? 33'd0 : scale_prod[48:16];
  end

  always_ff @(posedge clk) begin
    if (load[0]) vel_r[0] <= vel0_nxt;
    if (load[1]) vel_r[1] <= vel1_nxt;
    for (int k = 2; k <= slvl_pkg::ST_SCALE; k++) begin
      if (load[k]) vel_r[k] <= vel_r[k-1];
    end
    if (load[slvl_pkg::ST_PROD]) vel_r[slvl_pkg::ST_PROD] <= vel_prod_nxt;
  end

  slvl_scale_pipe u_scale (
    .clk   (clk),
    .load  (load[slvl_pkg::ST_SCALE:0]),
    .pos   (in_chan.current_position),
    .lim   ('{lower: lower_r, upper: upper_r}),
    .scale (scale)
  );

  // Output register: clamp, restore sign, activity flag
  logic [23:0]        cap, mag_clamp;
  logic signed [24:0] drive_r, drive_nxt;
  logic               active_r;

  always_comb begin
    cap       = {max_speed_r, 8'h00};
    mag_clamp = (vel_r[slvl_pkg::ST_PROD].mag > 33'(cap)) ? cap
                                                           : vel_r[slvl_pkg::ST_PROD].mag[23:0];
    drive_nxt = vel_r[slvl_pkg::ST_PROD].neg ? -$signed({1'b0, mag_clamp})
                                             : $signed({1'b0, mag_clamp});
  end

  always_ff @(posedge clk) begin
    if (load[slvl_pkg::ST_OUT]) begin
      drive_r  <= drive_nxt;
      active_r <= mag_clamp > slvl_pkg::ACTIVE_THRESHOLD;
    end
  end

  assign out_chan.valid          = valid_r[slvl_pkg::ST_OUT];
  assign out_chan.drive_velocity = drive_r;
  assign out_chan.axis_active    = active_r;

  logic in_acc, out_acc;
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  // Back-pressure reaches the input only when the whole pipe is full and stalled
  a_ready_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready))
    else $error("input stalled while output not blocked");

  // Occupancy moves only by accepted and delivered transactions
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> $countones(valid_r) ==
             $past($countones(valid_r)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("transaction lost or duplicated in pipeline");

  // Soft-limit scale never exceeds unity
  a_scale_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[slvl_pkg::ST_PROD] |-> $past(scale) <= slvl_pkg::Q16_ONE)
    else $error("scale above 1.0");

  // Positive output stays within the speed cap
  a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !drive_r[24]) |-> (drive_r[23:0] <= {max_speed_r, 8'h00}))
    else $error("drive velocity above max speed");

endmodule
